### rtl/adp_pkg.sv
// Shared types and constants for the data-processing ALU block.
`timescale 1ns / 1ps

package adp_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned NumRegs = 16;
  localparam int unsigned RegIdxW = $clog2(NumRegs);
  localparam int unsigned FuncW   = 4;

  typedef enum logic [FuncW-1:0] {
    OP_AND = 4'd0,
    OP_EOR = 4'd1,
    OP_SUB = 4'd2,
    OP_RSB = 4'd3,
    OP_ADD = 4'd4,
    OP_TST = 4'd8,
    OP_TEQ = 4'd9,
    OP_CMP = 4'd10,
    OP_ORR = 4'd12,
    OP_MOV = 4'd13
  } alu_op_e;

  typedef struct packed {
    logic n;
    logic z;
    logic c;
  } flags_t;

  // Outcome of one executed word.
  typedef struct packed {
    logic [DataW-1:0] res;
    logic             wr_en;
    logic             bad;
    flags_t           flags;
    logic [DataW-1:0] dest_value;
  } exec_t;

endpackage

### rtl/adp_ram.sv
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps

module adp_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

### rtl/adp_alu.sv
// Combinational execute logic: result, write enable, bad opcode, destination value and next flags.
`timescale 1ns / 1ps

module adp_alu (
  input  logic [adp_pkg::FuncW-1:0] func_i,
  input  logic                      set_flags_i,
  input  logic [adp_pkg::DataW-1:0] rn_val_i,
  input  logic [adp_pkg::DataW-1:0] rd_val_i,
  input  logic [adp_pkg::DataW-1:0] op2_i,
  input  adp_pkg::flags_t           flags_i,
  output adp_pkg::exec_t            exec_o
);
  import adp_pkg::*;

  logic [DataW:0]   sum;
  logic [DataW:0]   sub_ab;
  logic [DataW:0]   sub_ba;
  logic [DataW-1:0] res;
  logic             writes;
  logic             bad;
  logic             upd_c;
  logic             new_c;
  flags_t           flags_d;

  assign sum    = {1'b0, rn_val_i} + {1'b0, op2_i};
  assign sub_ab = {1'b0, rn_val_i} - {1'b0, op2_i};
  assign sub_ba = {1'b0, op2_i} - {1'b0, rn_val_i};

  always_comb begin
    res    = '0;
    writes = 1'b0;
    bad    = 1'b0;
    upd_c  = 1'b0;
    new_c  = 1'b0;
    unique case (alu_op_e'(func_i))
      OP_AND: begin res = rn_val_i & op2_i; writes = 1'b1; end
      OP_EOR: begin res = rn_val_i ^ op2_i; writes = 1'b1; end
      OP_ORR: begin res = rn_val_i | op2_i; writes = 1'b1; end
      OP_MOV: begin res = op2_i;            writes = 1'b1; end
      OP_SUB: begin
        res = sub_ab[DataW-1:0]; writes = 1'b1; upd_c = 1'b1; new_c = ~sub_ab[DataW];
      end
      OP_RSB: begin
        res = sub_ba[DataW-1:0]; writes = 1'b1; upd_c = 1'b1; new_c = ~sub_ba[DataW];
      end
      OP_ADD: begin
        res = sum[DataW-1:0]; writes = 1'b1; upd_c = 1'b1; new_c = sum[DataW];
      end
      OP_TST: res = rn_val_i & op2_i;
      OP_TEQ: res = rn_val_i ^ op2_i;
      OP_CMP: begin
        res = sub_ab[DataW-1:0]; upd_c = 1'b1; new_c = ~sub_ab[DataW];
      end
      default: bad = 1'b1;
    endcase
  end

  always_comb begin
    flags_d = flags_i;
    if (!bad && set_flags_i) begin
      flags_d.n = res[DataW-1];
      flags_d.z = (res == '0);
      if (upd_c) begin
        flags_d.c = new_c;
      end
    end
  end

  assign exec_o.res        = res;
  assign exec_o.wr_en      = writes & ~bad;
  assign exec_o.bad        = bad;
  assign exec_o.flags      = flags_d;
  assign exec_o.dest_value = (writes & ~bad) ? res : rd_val_i;

endmodule

### rtl/arm_data_processing_alu_top.sv
// Top level: ARM data-processing execute stage with register file and flags.
//
// Input channel: in_valid_i / in_stall_o with func_i, set_flags_i, src_index_i,
// dest_index_i and second_operand_i. A word is taken at a clock edge where
// in_valid_i is high and in_stall_o is low.
// Output channel: out_valid_o / out_stall_i with dest_value_o, the flags and
// bad_opcode_o. A result is taken where out_valid_o is high and out_stall_i low.
// An accepted word has the register file read into the operand stage,
// then the ALU writes the result register. Throughput: one word per
// cycle while out_stall_i does not hold a full result register, set by
// the combinational ALU between the operand register and the result
// register; a word's write back is forwarded into the next word's reads.
// Reset: all registers read as zero and the flags are clear; no words are
// in flight after reset, and words are accepted in the first cycle.
// Stall: while out_stall_i holds a full result register, the operand stage
// keeps its word and in_stall_o rises once that stage is occupied too.
`timescale 1ns / 1ps

module arm_data_processing_alu_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [adp_pkg::FuncW-1:0]   func_i,
  input  logic                        set_flags_i,
  input  logic [adp_pkg::RegIdxW-1:0] src_index_i,
  input  logic [adp_pkg::RegIdxW-1:0] dest_index_i,
  input  logic [adp_pkg::DataW-1:0]   second_operand_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [adp_pkg::DataW-1:0]   dest_value_o,
  output logic                        flag_n_o,
  output logic                        flag_z_o,
  output logic                        flag_c_o,
  output logic                        bad_opcode_o
);
  import adp_pkg::*;

  logic                in_acc;
  logic                fire;
  logic                s1_valid_q;
  logic [FuncW-1:0]    func_q;
  logic                set_flags_q;
  logic [RegIdxW-1:0]  dest_q;
  logic [DataW-1:0]    op2_q;
  logic                byp_a_q;
  logic                byp_b_q;
  logic [DataW-1:0]    byp_data_q;
  logic                vld_a_q;
  logic                vld_b_q;
  logic [NumRegs-1:0]  vld_q;
  logic [DataW-1:0]    ram_a;
  logic [DataW-1:0]    ram_b;
  logic [DataW-1:0]    rn_val;
  logic [DataW-1:0]    rd_val;
  flags_t              flags_q;
  exec_t               exec;
  logic                out_valid_q;
  logic [DataW-1:0]    dest_value_q;
  flags_t              out_flags_q;
  logic                bad_q;

  assign fire       = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = s1_valid_q & ~fire;
  assign in_acc     = in_valid_i & ~in_stall_o;

  adp_ram #(
    .Width(DataW),
    .Depth(NumRegs)
  ) u_regfile (
    .clk_i     (clk_i),
    .we_i      (exec.wr_en & fire),
    .waddr_i   (dest_q),
    .wdata_i   (exec.res),
    .re_i      (in_acc),
    .raddr_a_i (src_index_i),
    .raddr_b_i (dest_index_i),
    .rdata_a_o (ram_a),
    .rdata_b_o (ram_b)
  );

  // Entries never written read as zero; same-edge write back is forwarded.
  assign rn_val = byp_a_q ? byp_data_q : (vld_a_q ? ram_a : '0);
  assign rd_val = byp_b_q ? byp_data_q : (vld_b_q ? ram_b : '0);

  adp_alu u_alu (
    .func_i      (func_q),
    .set_flags_i (set_flags_q),
    .rn_val_i    (rn_val),
    .rd_val_i    (rd_val),
    .op2_i       (op2_q),
    .flags_i     (flags_q),
    .exec_o      (exec)
  );

  // Operand stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      vld_q      <= '0;
      flags_q    <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (fire) begin
        s1_valid_q <= 1'b0;
      end
      if (fire) begin
        flags_q <= exec.flags;
        if (exec.wr_en) begin
          vld_q[dest_q] <= 1'b1;
        end
      end
    end
  end

  // Operand stage payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q      <= func_i;
      set_flags_q <= set_flags_i;
      dest_q      <= dest_index_i;
      op2_q       <= second_operand_i;
      byp_a_q     <= fire & exec.wr_en & (dest_q == src_index_i);
      byp_b_q     <= fire & exec.wr_en & (dest_q == dest_index_i);
      byp_data_q  <= exec.res;
      vld_a_q     <= vld_q[src_index_i];
      vld_b_q     <= vld_q[dest_index_i];
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      dest_value_q <= exec.dest_value;
      out_flags_q  <= exec.flags;
      bad_q        <= exec.bad;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign dest_value_o = dest_value_q;
  assign flag_n_o     = out_flags_q.n;
  assign flag_z_o     = out_flags_q.z;
  assign flag_c_o     = out_flags_q.c;
  assign bad_opcode_o = bad_q;

  // An unsupported opcode leaves the flags untouched.
  a_bad_keeps_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && exec.bad |=> flags_q == $past(flags_q))
    else $error("flags changed on unsupported opcode");

  // A word that does not write leaves the written-entry map alone.
  a_no_write_keeps_vld: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !exec.wr_en |=> $stable(vld_q))
    else $error("register map changed without a write");

  // The result register drains when taken and nothing new arrives.
  a_out_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_stall_i && !fire |=> !out_valid_q)
    else $error("result register did not drain");

  // A stalled result keeps its word.
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(dest_value_q)
      && $stable(out_flags_q) && $stable(bad_q))
    else $error("stalled result changed");

endmodule

### test/tb_arm_data_processing_alu_top.sv
// Self-checking testbench for the data-processing ALU with register file and flags.
`timescale 1ns / 1ps

module tb_arm_data_processing_alu_top;
  import adp_pkg::*;

  localparam int unsigned StallLimit = 5000;
  localparam int unsigned DrainCycles = 8;

  typedef struct packed {
    logic [DataW-1:0] dest_value;
    logic             n;
    logic             z;
    logic             c;
    logic             bad;
  } alu_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [FuncW-1:0]     func_i;
  logic                 set_flags_i;
  logic [RegIdxW-1:0]   src_index_i;
  logic [RegIdxW-1:0]   dest_index_i;
  logic [DataW-1:0]     second_operand_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [DataW-1:0]     dest_value_o;
  logic                 flag_n_o;
  logic                 flag_z_o;
  logic                 flag_c_o;
  logic                 bad_opcode_o;

  // Architectural state as the testbench sees it.
  logic [DataW-1:0]     gold_regs [NumRegs];
  flags_t               gold_flags;
  alu_result_t          pending_results [$];

  int unsigned          idle_pct;
  int unsigned          stall_pct;
  int unsigned          error_count;
  int unsigned          quiet_cycles;

  arm_data_processing_alu_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .set_flags_i     (set_flags_i),
    .src_index_i     (src_index_i),
    .dest_index_i    (dest_index_i),
    .second_operand_i(second_operand_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .dest_value_o    (dest_value_o),
    .flag_n_o        (flag_n_o),
    .flag_z_o        (flag_z_o),
    .flag_c_o        (flag_c_o),
    .bad_opcode_o    (bad_opcode_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Execute one accepted word on the shadow state and queue its result.
  task automatic execute_word(input logic [FuncW-1:0] func, input logic s,
                              input logic [RegIdxW-1:0] rn, input logic [RegIdxW-1:0] rd,
                              input logic [DataW-1:0] op2);
    logic [DataW-1:0] a;
    logic [DataW:0]   sum;
    logic [DataW-1:0] res;
    logic             writes;
    logic             bad;
    alu_result_t      r;
    a = gold_regs[rn];
    res = '0;
    writes = 1'b0;
    bad = 1'b0;
    case (func)
      OP_AND: begin res = a & op2; writes = 1'b1; end
      OP_EOR: begin res = a ^ op2; writes = 1'b1; end
      OP_ORR: begin res = a | op2; writes = 1'b1; end
      OP_MOV: begin res = op2;     writes = 1'b1; end
      OP_SUB: begin
        res = a - op2; writes = 1'b1;
        if (s) gold_flags.c = (a >= op2);
      end
      OP_RSB: begin
        res = op2 - a; writes = 1'b1;
        if (s) gold_flags.c = (op2 >= a);
      end
      OP_ADD: begin
        sum = {1'b0, a} + {1'b0, op2};
        res = sum[DataW-1:0]; writes = 1'b1;
        if (s) gold_flags.c = sum[DataW];
      end
      OP_TST: res = a & op2;
      OP_TEQ: res = a ^ op2;
      OP_CMP: begin
        res = a - op2;
        if (s) gold_flags.c = (a >= op2);
      end
      default: bad = 1'b1;
    endcase
    if (!bad) begin
      if (writes) gold_regs[rd] = res;
      if (s) begin
        gold_flags.z = (res == '0);
        gold_flags.n = res[DataW-1];
      end
    end
    r.dest_value = gold_regs[rd];
    r.n = gold_flags.n;
    r.z = gold_flags.z;
    r.c = gold_flags.c;
    r.bad = bad;
    pending_results.push_back(r);
  endtask

  // Present one word, idling first at the current rate, and wait until it is taken.
  task automatic send_word(input logic [FuncW-1:0] func, input logic s,
                           input logic [RegIdxW-1:0] rn, input logic [RegIdxW-1:0] rd,
                           input logic [DataW-1:0] op2);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      // junk on the payload while valid is low
      in_valid_i       <= 1'b0;
      func_i           <= FuncW'($urandom_range(15));
      set_flags_i      <= 1'($urandom_range(1));
      src_index_i      <= RegIdxW'($urandom_range(15));
      dest_index_i     <= RegIdxW'($urandom_range(15));
      second_operand_i <= $urandom();
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    func_i           <= func;
    set_flags_i      <= s;
    src_index_i      <= rn;
    dest_index_i     <= rd;
    second_operand_i <= op2;
    do @(posedge clk_i); while (in_stall_o);
    execute_word(func, s, rn, rd, op2);
  endtask

  // Hold the sender off until every outstanding result has come back.
  task automatic wait_results_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_moves_and_logic();
    send_word(OP_MOV, 1'b1, 4'd0, 4'd1, 32'hFFFF_FFFF);
    send_word(OP_MOV, 1'b1, 4'd0, 4'd2, 32'h0000_0000);
    send_word(OP_MOV, 1'b0, 4'd0, 4'd15, 32'h8000_0000);  // r15 is an ordinary register
    send_word(OP_AND, 1'b1, 4'd1, 4'd7, 32'h0000_FFFF);
    send_word(OP_EOR, 1'b1, 4'd1, 4'd8, 32'hFFFF_FFFF);
    send_word(OP_ORR, 1'b1, 4'd15, 4'd9, 32'h0000_0001);
  endtask

  task automatic test_arith_carry();
    send_word(OP_ADD, 1'b1, 4'd1, 4'd3, 32'h0000_0001);   // wraps to zero, carry out
    send_word(OP_SUB, 1'b1, 4'd2, 4'd4, 32'h0000_0000);   // equal operands set carry
    send_word(OP_SUB, 1'b1, 4'd2, 4'd5, 32'h0000_0001);   // borrow
    send_word(OP_RSB, 1'b1, 4'd15, 4'd6, 32'h0000_0005);
    send_word(OP_RSB, 1'b1, 4'd1, 4'd10, 32'hFFFF_FFFF);
    send_word(OP_ADD, 1'b0, 4'd15, 4'd15, 32'h8000_0000);
    send_word(OP_RSB, 1'b0, 4'd7, 4'd7, 32'h7FFF_FFFF);
  endtask

  task automatic test_compare_ops();
    send_word(OP_TST, 1'b1, 4'd9, 4'd9, 32'h8000_0000);
    send_word(OP_TEQ, 1'b1, 4'd1, 4'd1, 32'hFFFF_FFFF);
    send_word(OP_CMP, 1'b1, 4'd2, 4'd2, 32'h0000_0000);
    // without S these leave everything alone
    send_word(OP_TST, 1'b0, 4'd1, 4'd3, 32'hFFFF_FFFF);
    send_word(OP_TEQ, 1'b0, 4'd1, 4'd4, 32'h0000_0000);
    send_word(OP_CMP, 1'b0, 4'd2, 4'd5, 32'hFFFF_FFFF);
  endtask

  task automatic test_bad_opcodes();
    send_word(4'd5,  1'b1, 4'd1, 4'd1, 32'h0000_0000);
    send_word(4'd6,  1'b0, 4'd2, 4'd2, 32'hFFFF_FFFF);
    send_word(4'd7,  1'b1, 4'd3, 4'd15, 32'h1234_5678);
    send_word(4'd11, 1'b0, 4'd4, 4'd6, 32'h8000_0000);
    send_word(4'd14, 1'b1, 4'd5, 4'd7, 32'h0000_0001);
    send_word(4'd15, 1'b0, 4'd6, 4'd8, 32'h7FFF_FFFF);
  endtask

  // Mostly supported opcodes; the rest are drawn from the full range.
  function automatic logic [FuncW-1:0] random_func();
    case ($urandom_range(11))
      0:  return OP_AND;
      1:  return OP_EOR;
      2:  return OP_SUB;
      3:  return OP_RSB;
      4:  return OP_ADD;
      5:  return OP_TST;
      6:  return OP_TEQ;
      7:  return OP_CMP;
      8:  return OP_ORR;
      9:  return OP_MOV;
      default: return FuncW'($urandom_range(15));
    endcase
  endfunction

  // Corner values and values near Rn so that equal, zero and wrap cases come up often.
  function automatic logic [DataW-1:0] random_operand(input logic [DataW-1:0] rn_value);
    case ($urandom_range(11))
      0:  return 32'h0000_0000;
      1:  return 32'hFFFF_FFFF;
      2:  return 32'h8000_0000;
      3:  return 32'h7FFF_FFFF;
      4:  return rn_value;
      5:  return rn_value + 32'd1;
      6:  return rn_value - 32'd1;
      7:  return ~rn_value;
      8:  return -rn_value;
      default: return $urandom();
    endcase
  endfunction

  task automatic test_random(input int unsigned count, input int unsigned idle,
                             input int unsigned stall);
    logic [RegIdxW-1:0] rn;
    idle_pct = idle;
    stall_pct = stall;
    repeat (count) begin
      rn = RegIdxW'($urandom_range(15));
      send_word(random_func(), 1'($urandom_range(1)), rn, RegIdxW'($urandom_range(15)),
                random_operand(gold_regs[rn]));
    end
    wait_results_drained();
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin : check_results
    alu_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: dest_value %h", dest_value_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (dest_value_o !== want.dest_value) begin
          $error("dest_value expected %h got %h", want.dest_value, dest_value_o);
          error_count++;
        end
        if (flag_n_o !== want.n) begin
          $error("flag_n expected %b got %b", want.n, flag_n_o);
          error_count++;
        end
        if (flag_z_o !== want.z) begin
          $error("flag_z expected %b got %b", want.z, flag_z_o);
          error_count++;
        end
        if (flag_c_o !== want.c) begin
          $error("flag_c expected %b got %b", want.c, flag_c_o);
          error_count++;
        end
        if (bad_opcode_o !== want.bad) begin
          $error("bad_opcode expected %b got %b", want.bad, bad_opcode_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog: too long without a word moving on either side ends the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("tb_arm_data_processing_alu_top NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    out_stall_i      = 1'b0;
    func_i           = '0;
    set_flags_i      = 1'b0;
    src_index_i      = '0;
    dest_index_i     = '0;
    second_operand_i = '0;
    idle_pct         = 0;
    stall_pct        = 0;
    error_count      = 0;
    quiet_cycles     = 0;
    gold_flags       = '0;
    for (int i = 0; i < NumRegs; i++) gold_regs[i] = '0;

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_moves_and_logic();
    test_arith_carry();
    test_compare_ops();
    test_bad_opcodes();
    wait_results_drained();

    test_random(450, 0, 0);
    test_random(420, 86, 0);
    test_random(420, 0, 86);
    test_random(450, 25, 25);

    stall_pct = 0;
    repeat (DrainCycles) @(negedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("tb_arm_data_processing_alu_top OK");
    end else begin
      $display("tb_arm_data_processing_alu_top NOT OK");
    end
    $finish;
  end

endmodule

### arm_data_processing_alu_top.f
rtl/adp_pkg.sv
rtl/adp_ram.sv
rtl/adp_alu.sv
rtl/arm_data_processing_alu_top.sv
test/tb_arm_data_processing_alu_top.sv
